// ===== rtl/first_fit_heap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_macros
// Assertion shorthands for the heap allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffha assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffha assertion failed");

`endif

// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int          MAX_BLOCKS_DEF = 1024;
   localparam logic [31:0] HEADER_BYTES   = 32'd8;
   localparam logic [31:0] GAP_BYTES      = 32'd4;
   localparam logic [31:0] STRIDE_EXTRA   = HEADER_BYTES + GAP_BYTES;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      OUT_OK        = 3'd0,
      OUT_ZERO_SIZE = 3'd1,
      OUT_NO_MEMORY = 3'd2,
      OUT_NOT_FOUND = 3'd3,
      OUT_TABLE_FULL = 3'd4
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_TAIL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef enum logic {
      REG_HEAP_START = 1'b0,
      REG_HEAP_LIMIT = 1'b1
   } reg_type;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over a block table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Each word on req is an allocate or a free and yields exactly one word on
// rsp. Both operations walk the block table from the first entry, one entry
// per clock through the single read port of the table RAM. An allocate whose
// walk misses goes on to a tail step that checks the heap end and appends; a
// free whose walk misses answers not found. A zero-size allocate answers
// without a walk. The table needs no clearing after reset; only entries
// below the block count are read.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] request_bytes, [63:32] release_address
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] payload_address, [63:32] bytes_in_use
   output logic [2:0]  rsp_tuser,   // [2:0] outcome
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ffha_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int TW = IW + 1;
   localparam logic [TW-1:0] TOTAL_MAX = TW'(MAX_BLOCKS);

   // table entry: [32] taken, [31:0] length
   logic [32:0]       block_mem [MAX_BLOCKS];
   logic [32:0]       rd_data_ff;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [32:0]       wr_data;

   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [31:0]       pos_ff, pos_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [31:0]       fill_ff, fill_in;
   logic [31:0]       used_ff, used_in;
   logic [31:0]       heap_start_ff, heap_limit_ff;
   op_type            op_ff;
   logic [31:0]       req_bytes_ff;
   logic [31:0]       rel_addr_ff;
   logic [31:0]       res_addr_ff, res_addr_in;
   outcome_type       res_outcome_ff, res_outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_addr_ff;
   outcome_type       rsp_outcome_ff;
   logic [31:0]       rsp_used_ff;

   logic              req_accept;
   logic              out_free;
   logic              csr_write;
   logic              entry_taken;
   logic [31:0]       entry_length;
   logic              walk_last;
   logic              alloc_fit;
   logic              free_match;
   logic [33:0]       end_sum;
   logic              append_ok;

   assign req_accept   = req_tvalid && req_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready   = 1'b1;
   assign csr_prdata   = (reg_type'(csr_paddr[2]) == REG_HEAP_LIMIT) ? heap_limit_ff
                                                                    : heap_start_ff;

   assign entry_taken  = rd_data_ff[32];
   assign entry_length = rd_data_ff[31:0];
   assign walk_last    = (({1'b0, idx_ff}) + TW'(1)) == total_ff;
   assign alloc_fit    = !entry_taken && (entry_length >= req_bytes_ff);
   assign free_match   = (pos_ff == rel_addr_ff);
   assign end_sum      = {2'b00, heap_start_ff} + {2'b00, fill_ff} + {2'b00, req_bytes_ff}
                         + {2'b00, HEADER_BYTES};
   assign append_ok    = (end_sum < {2'b00, heap_limit_ff}) && (total_ff < TOTAL_MAX);

   assign rd_addr      = idx_in;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      total_in       = total_ff;
      fill_in        = fill_ff;
      used_in        = used_ff;
      res_addr_in    = res_addr_ff;
      res_outcome_in = res_outcome_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = {1'b1, entry_length};
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            pos_in = heap_start_ff + HEADER_BYTES;
            if (req_accept) begin
               res_addr_in = '0;
               if (op_type'(req_tuser) == OP_ALLOC && req_tdata[31:0] == 32'd0) begin
                  res_outcome_in = OUT_ZERO_SIZE;
                  state_in       = ST_DONE;
               end else if (total_ff == '0) begin
                  if (op_type'(req_tuser) == OP_ALLOC) begin
                     state_in = ST_TAIL;
                  end else begin
                     res_outcome_in = OUT_NOT_FOUND;
                     state_in       = ST_DONE;
                  end
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (op_ff == OP_ALLOC && alloc_fit) begin
               wr_en          = 1'b1;
               wr_data        = {1'b1, entry_length};
               used_in        = used_ff + req_bytes_ff + HEADER_BYTES;
               res_addr_in    = pos_ff;
               res_outcome_in = OUT_OK;
               state_in       = ST_DONE;
            end else if (op_ff == OP_FREE && free_match) begin
               wr_en          = 1'b1;
               wr_data        = {1'b0, entry_length};
               used_in        = used_ff - (entry_length + HEADER_BYTES);
               res_addr_in    = '0;
               res_outcome_in = OUT_OK;
               state_in       = ST_DONE;
            end else if (walk_last) begin
               idx_in = '0;
               if (op_ff == OP_ALLOC) begin
                  state_in = ST_TAIL;
               end else begin
                  res_addr_in    = '0;
                  res_outcome_in = OUT_NOT_FOUND;
                  state_in       = ST_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               pos_in = pos_ff + entry_length + STRIDE_EXTRA;
            end
         end
         ST_TAIL: begin
            idx_in   = '0;
            state_in = ST_DONE;
            if (end_sum >= {2'b00, heap_limit_ff}) begin
               res_addr_in    = '0;
               res_outcome_in = OUT_NO_MEMORY;
            end else if (!append_ok) begin
               res_addr_in    = '0;
               res_outcome_in = OUT_TABLE_FULL;
            end else begin
               wr_en          = 1'b1;
               wr_addr        = total_ff[IW-1:0];
               wr_data        = {1'b1, req_bytes_ff};
               total_in       = total_ff + TW'(1);
               fill_in        = fill_ff + req_bytes_ff + STRIDE_EXTRA;
               used_in        = used_ff + req_bytes_ff + STRIDE_EXTRA;
               res_addr_in    = heap_start_ff + fill_ff + HEADER_BYTES;
               res_outcome_in = OUT_OK;
            end
         end
         ST_DONE: begin
            idx_in = '0;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= block_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         total_ff      <= '0;
         fill_ff       <= '0;
         used_ff       <= '0;
         heap_start_ff <= '0;
         heap_limit_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         fill_ff      <= fill_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            if (reg_type'(csr_paddr[2]) == REG_HEAP_LIMIT) begin
               heap_limit_ff <= csr_pwdata;
            end else begin
               heap_start_ff <= csr_pwdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      res_addr_ff    <= res_addr_in;
      res_outcome_ff <= res_outcome_in;
      if (req_accept) begin
         op_ff        <= op_type'(req_tuser);
         req_bytes_ff <= req_tdata[31:0];
         rel_addr_ff  <= req_tdata[63:32];
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_addr_ff    <= res_addr_ff;
         rsp_outcome_ff <= res_outcome_ff;
         rsp_used_ff    <= used_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_used_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_outcome_ff;

`include "first_fit_heap_allocator_macros.svh"

   `FFHA_ASSERT_NOW(a_total_bound, clock, reset, 1'b1, total_ff <= TOTAL_MAX)
   `FFHA_ASSERT_NOW(a_walk_in_table, clock, reset, state_ff == ST_WALK,
                    ({1'b0, idx_ff}) < total_ff)
   `FFHA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   `FFHA_ASSERT_NEXT(a_append_counts, clock, reset, state_ff == ST_TAIL && append_ok,
                     total_ff == $past(total_ff) + TW'(1))

endmodule

// ===== bench/heap_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// heap_alloc_checker
// Watches the request, response and register ports of the heap allocator,
// keeps its own copy of the block table and byte counter, and compares every
// response word field by field against the oldest owed answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_alloc_checker #(
   parameter int TABLE_DEPTH = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] request_bytes, [63:32] release_address
   input  logic        req_tuser,   // [0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] payload_address, [63:32] bytes_in_use
   input  logic [2:0]  rsp_tuser,   // [2:0] outcome
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          owed_count,
   output int          table_entries,
   output int          mismatch_total
);
   import ffha_pkg::*;

   typedef struct {
      logic [31:0] payload;
      outcome_type outcome;
      logic [31:0] in_use;
   } heap_answer_type;

   logic [31:0]     blk_len   [TABLE_DEPTH];
   bit              blk_taken [TABLE_DEPTH];
   int unsigned     blk_count;
   logic [31:0]     heap_base;
   logic [31:0]     heap_top;
   logic [31:0]     fill_off;
   logic [31:0]     used_bytes;
   heap_answer_type owed_q [$];

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatch_total++;
   endtask

   // first-fit walk over the table; updates the table and counter in place
   task automatic walk_heap_table(input op_type op, input logic [31:0] size,
                                  input logic [31:0] addr, output heap_answer_type ans);
      logic [31:0] off;
      logic [63:0] tail;
      bit          hit;
      int          i;
      off         = '0;
      hit         = 1'b0;
      ans.payload = '0;
      ans.outcome = OUT_OK;
      if (op == OP_ALLOC) begin
         if (size == 32'd0) begin
            ans.outcome = OUT_ZERO_SIZE;
         end else begin
            for (i = 0; i < blk_count && !hit; i++) begin
               if (!blk_taken[i] && blk_len[i] >= size) begin
                  hit          = 1'b1;
                  blk_taken[i] = 1'b1;
                  used_bytes   += size + HEADER_BYTES;
                  ans.payload  = heap_base + off + HEADER_BYTES;
               end else begin
                  off += blk_len[i] + STRIDE_EXTRA;
               end
            end
            if (!hit) begin
               // heap end test is done without wrapping
               tail = 64'(heap_base) + 64'(fill_off) + 64'(size) + 64'(HEADER_BYTES);
               if (tail >= 64'(heap_top)) begin
                  ans.outcome = OUT_NO_MEMORY;
               end else if (blk_count >= TABLE_DEPTH) begin
                  ans.outcome = OUT_TABLE_FULL;
               end else begin
                  blk_len[blk_count]   = size;
                  blk_taken[blk_count] = 1'b1;
                  blk_count++;
                  ans.payload = heap_base + fill_off + HEADER_BYTES;
                  fill_off    += size + STRIDE_EXTRA;
                  used_bytes  += size + STRIDE_EXTRA;
               end
            end
         end
      end else begin
         ans.outcome = OUT_NOT_FOUND;
         for (i = 0; i < blk_count && !hit; i++) begin
            if (heap_base + off + HEADER_BYTES == addr) begin
               hit          = 1'b1;
               blk_taken[i] = 1'b0;
               used_bytes   -= blk_len[i] + HEADER_BYTES;
               ans.outcome  = OUT_OK;
            end else begin
               off += blk_len[i] + STRIDE_EXTRA;
            end
         end
      end
      ans.in_use = used_bytes;
   endtask

   always @(posedge clock) begin
      heap_answer_type want;
      heap_answer_type fresh;
      if (reset) begin
         blk_count  = 0;
         fill_off   = '0;
         used_bytes = '0;
         heap_base  = '0;
         heap_top   = '0;
         owed_q.delete();
      end else begin
         // retire before accepting, so a new word never answers itself
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               note_mismatch("response with nothing owed", rsp_tdata[31:0], '0);
            end else begin
               want = owed_q.pop_front();
               if (rsp_tdata[31:0] !== want.payload)
                  note_mismatch("payload_address", rsp_tdata[31:0], want.payload);
               if (rsp_tuser !== want.outcome)
                  note_mismatch("outcome", 32'(rsp_tuser), 32'(want.outcome));
               if (rsp_tdata[63:32] !== want.in_use)
                  note_mismatch("bytes_in_use", rsp_tdata[63:32], want.in_use);
            end
         end
         if (req_tvalid && req_tready) begin
            walk_heap_table(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32], fresh);
            owed_q.push_back(fresh);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            case (reg_type'(csr_paddr[2]))
               REG_HEAP_START: heap_base = csr_pwdata;
               REG_HEAP_LIMIT: heap_top  = csr_pwdata;
               default: ;
            endcase
         end
      end
      owed_count    <= owed_q.size();
      table_entries <= blk_count;
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the first-fit heap allocator. A directed opening
// covers the heap-end boundary, wrapped fill offsets, shared payload
// addresses, double free and unmatched free; four random phases with
// different heap windows and pacing follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ffha_pkg::*;

   typedef enum int {
      PACE_STEADY,
      PACE_SRC_IDLE,
      PACE_SINK_STALL,
      PACE_BOTH
   } pace_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // [31:0] request_bytes, [63:32] release_address
   logic        req_tuser   = OP_ALLOC;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;          // [31:0] payload_address, [63:32] bytes_in_use
   logic [2:0]  rsp_tuser;          // [2:0] outcome
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          owed;
   int          entries;
   int          faults;
   pace_type    pace        = PACE_STEADY;
   bit          hold_go     = 1'b0;
   bit          hold_used   = 1'b0;
   int          hold_left   = 0;
   logic [31:0] live_addrs [$];
   int          n_alloc     = 0;
   int          n_free      = 0;
   int          n_cfg       = 0;

   always #5 clock = ~clock;

   first_fit_heap_allocator dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   heap_alloc_checker watch (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .owed_count(owed), .table_entries(entries), .mismatch_total(faults)
   );

   function automatic int pace_pct(input bit sink_side);
      case (pace)
         PACE_SRC_IDLE:   return sink_side ? 0 : 68;
         PACE_SINK_STALL: return sink_side ? 68 : 0;
         PACE_BOTH:       return 28;
         default:         return 0;
      endcase
   endfunction

   // response side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_used) begin
         rsp_tready <= 1'b0;
         hold_left  <= 300;
         hold_used  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= pace_pct(1'b1));
      end
   end

   // granted payload addresses, used later as free targets
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && outcome_type'(rsp_tuser) == OUT_OK
          && rsp_tdata[31:0] != 32'd0)
         live_addrs.push_back(rsp_tdata[31:0]);
   end

   task automatic push_word(input op_type op, input logic [31:0] size,
                            input logic [31:0] addr);
      int idle;
      idle = pace_pct(1'b0);
      if ($urandom_range(99) < idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {addr, size};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_ALLOC) n_alloc++;
      else n_free++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type which, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      n_cfg++;
      @(posedge clock);
   endtask

   task automatic set_window(input logic [31:0] base, input logic [31:0] lim);
      settle();
      csr_write(REG_HEAP_START, base);
      csr_write(REG_HEAP_LIMIT, lim);
      live_addrs.delete();
   endtask

   task automatic random_word();
      int          pick;
      int          idx;
      logic [31:0] addr;
      pick = $urandom_range(99);
      if (pick < 45) begin
         push_word(OP_ALLOC, $urandom_range(48, 1), $urandom());
      end else if (pick < 55) begin
         push_word(OP_ALLOC, $urandom_range(600, 1), $urandom());
      end else if (pick < 60) begin
         push_word(OP_ALLOC, $urandom(), $urandom());
      end else if (pick < 63) begin
         push_word(OP_ALLOC, 32'd0, $urandom());
      end else if (pick < 90 && live_addrs.size() != 0) begin
         idx  = $urandom_range(live_addrs.size() - 1);
         addr = live_addrs[idx];
         live_addrs.delete(idx);
         push_word(OP_FREE, $urandom(), addr);
      end else if (pick < 95 && live_addrs.size() != 0) begin
         // near miss: four bytes past a payload start, not at its start
         addr = live_addrs[$urandom_range(live_addrs.size() - 1)] + 32'd4;
         push_word(OP_FREE, $urandom(), addr);
      end else begin
         push_word(OP_FREE, $urandom(), $urandom());
      end
   endtask

   initial begin
      logic [31:0] bases  [4];
      logic [31:0] limits [4];
      pace_type    paces  [4];

      bases  = '{32'h0001_0000, 32'h0004_0000, 32'hFFFF_F000, 32'h8000_0000};
      limits = '{32'h0001_0700, 32'h0004_0900, 32'hFFFF_FFFF, 32'h8000_1200};
      paces  = '{PACE_STEADY, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset window: limit zero, empty table
      push_word(OP_ALLOC, 32'd5, 32'd0);
      push_word(OP_FREE, 32'd0, 32'd8);

      set_window(32'h0000_0000, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
      push_word(OP_ALLOC, 32'hFFFF_FFF7, 32'd0);    // end lands exactly on limit
      push_word(OP_ALLOC, 32'hFFFF_FFF4, 32'd0);    // fill offset wraps to zero
      push_word(OP_ALLOC, 32'd4, 32'd0);            // same payload address as first
      push_word(OP_FREE, 32'd0, 32'd8);
      push_word(OP_FREE, 32'hFFFF_FFFF, 32'd8);     // already free
      push_word(OP_FREE, 32'd0, 32'h1234_5678);
      push_word(OP_ALLOC, 32'd1, 32'hFFFF_FFFF);    // reuse of the huge free block

      set_window(32'hFFFF_FFF0, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'h20, 32'd0);           // fits only if the sum wrapped

      set_window(32'hFFFF_FF00, 32'hFFFF_FFFF);
      push_word(OP_ALLOC, 32'h10, 32'd0);
      push_word(OP_FREE, 32'd0, 32'hFFFF_FF18);
      push_word(OP_ALLOC, 32'h10, 32'd0);           // exact fit
      push_word(OP_ALLOC, 32'd203, 32'd0);
      push_word(OP_ALLOC, 32'd202, 32'd0);
      push_word(OP_FREE, 32'd0, 32'hFFFF_FF18);

      for (int p = 0; p < 4; p++) begin
         set_window(bases[p], limits[p]);
         pace = paces[p];
         if (p == 0) hold_go <= 1'b1;
         repeat (140) random_word();
      end

      settle();
      repeat (1100) @(posedge clock);
      $display("covered %0d words: %0d allocates, %0d frees, %0d register writes, four pacings",
               n_alloc + n_free, n_alloc, n_free, n_cfg);
      $display("block table reached %0d entries, with wrapped offsets and shared addresses",
               entries);
      if (faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("timeout with %0d responses still owed", owed);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
